[rtl/core/multi_channel_quiet_debouncer_macros.svh]
// Assertion macros shared by the debouncer RTL.
`ifndef MULTI_CHANNEL_QUIET_DEBOUNCER_MACROS_SVH
`define MULTI_CHANNEL_QUIET_DEBOUNCER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MCQD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("mcqd assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MCQD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("mcqd assertion failed");

`endif

[rtl/core/mcqd_pkg.sv]
// Shared types and constants of the quiet-period debouncer.
`default_nettype none

package mcqd_pkg;

    // Fixed widths of the transaction fields and configuration registers.
    localparam int FIELD_W = 4;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_BUTTON_QUIET = 2'd0;
    localparam logic [INDEX_W-1:0] REG_SENSOR_QUIET = 2'd1;
    localparam logic [INDEX_W-1:0] REG_SENSOR_SEL   = 2'd2;
    localparam logic [INDEX_W-1:0] REG_ACTIVE_LOW   = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0]   BUTTON_QUIET_RST = 16'd20;
    localparam logic [CFG_W-1:0]   SENSOR_QUIET_RST = 16'd5;
    localparam logic [FIELD_W-1:0] SENSOR_SEL_RST   = 4'h8;
    localparam logic [FIELD_W-1:0] ACTIVE_LOW_RST   = 4'hf;

    // Control from the top level to every lane.
    typedef struct packed {
        logic accept;
        logic primed;
    } t_lane_ctl;

    // What one lane found for the current transaction.
    typedef struct packed {
        logic stable;
        logic changed;
    } t_lane_res;

endpackage

`default_nettype wire

[rtl/core/mcqd_lane.sv]
// One debounce lane: edge detect, quiet countdown and stable level of one line.
`default_nettype none

module mcqd_lane #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire mcqd_pkg::t_lane_ctl    i_ctl,
    input  wire logic                   i_raw,
    input  wire logic                   i_active_low,
    input  wire logic [COUNT_WIDTH-1:0] i_quiet_len,
    output mcqd_pkg::t_lane_res         o_res
);

    logic                   r_prev;
    logic                   r_pending;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_stable;

    logic                   n_prev;
    logic                   n_pending;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   n_stable;

    logic active;
    logic edge_seen;
    logic pend_mid;
    logic fire;
    logic flip;

    always_comb begin
        active    = i_raw ^ i_active_low;
        edge_seen = i_raw ^ r_prev;
        pend_mid  = r_pending | edge_seen;
        n_count   = r_count;
        n_prev    = i_raw;
        fire      = 1'b0;
        flip      = 1'b0;
        if (!i_ctl.primed) begin
            // First transaction: load the level without flagging.
            n_pending = 1'b0;
            n_stable  = active;
        end else begin
            if (edge_seen) begin
                n_count = i_quiet_len;
            end else if (r_pending && (r_count != '0)) begin
                n_count = r_count - 1'b1;
            end
            fire      = pend_mid && (n_count == '0);
            n_pending = pend_mid && !fire;
            flip      = fire && (active != r_stable);
            n_stable  = r_stable ^ flip;
        end
        o_res.stable  = n_stable;
        o_res.changed = flip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= 1'b0;
            r_pending <= 1'b0;
            r_count   <= '0;
            r_stable  <= 1'b0;
        end else if (i_ctl.accept) begin
            r_prev    <= n_prev;
            r_pending <= n_pending;
            r_count   <= n_count;
            r_stable  <= n_stable;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mcqd_outbuf.sv]
// Merge of the lane results into result vectors, with output register and skid stage.
`default_nettype none

module mcqd_outbuf #(
    parameter int LINE_COUNT = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire mcqd_pkg::t_lane_res    i_lane [LINE_COUNT],
    output logic                        o_full,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [mcqd_pkg::FIELD_W-1:0] o_stable_levels,
    output logic [mcqd_pkg::FIELD_W-1:0] o_changed_mask
);

    logic [mcqd_pkg::FIELD_W-1:0] w_stable;
    logic [mcqd_pkg::FIELD_W-1:0] w_changed;

    logic                          r_out_valid;
    logic [mcqd_pkg::FIELD_W-1:0]  r_out_stable;
    logic [mcqd_pkg::FIELD_W-1:0]  r_out_changed;
    logic                          r_skid_valid;
    logic [mcqd_pkg::FIELD_W-1:0]  r_skid_stable;
    logic [mcqd_pkg::FIELD_W-1:0]  r_skid_changed;

    logic taken;

    // Lines beyond the field width are dropped; missing lines read as zero.
    always_comb begin
        w_stable  = '0;
        w_changed = '0;
        for (int i = 0; i < mcqd_pkg::FIELD_W; i++) begin
            if (i < LINE_COUNT) begin
                w_stable[i]  = i_lane[i].stable;
                w_changed[i] = i_lane[i].changed;
            end
        end
    end

    assign taken = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (taken) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (taken && r_skid_valid) begin
            r_out_stable  <= r_skid_stable;
            r_out_changed <= r_skid_changed;
        end else if (i_push && (taken || !r_out_valid)) begin
            r_out_stable  <= w_stable;
            r_out_changed <= w_changed;
        end
        if (i_push && r_out_valid && !taken) begin
            r_skid_stable  <= w_stable;
            r_skid_changed <= w_changed;
        end
    end

    assign o_full          = r_skid_valid;
    assign o_valid         = r_out_valid;
    assign o_stable_levels = r_out_stable;
    assign o_changed_mask  = r_out_changed;

endmodule

`default_nettype wire

[rtl/core/multi_channel_quiet_debouncer.sv]
// Top level of the multi-line quiet-period debouncer.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_stall    i_raw_levels
//   output    out        o_valid / i_stall    o_stable_levels, o_changed_mask
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One transaction per cycle while o_stall is low; its result is registered in the
// output register, or in the skid stage when that is occupied. All lanes update
// their state in the acceptance cycle, so the next transaction sees that state.
// Reset (synchronous, active low) clears all line state and loads the
// register defaults; the first transaction afterwards only loads the levels.
// An output register plus a skid stage hold up to two results; o_stall rises
// only when both are occupied.
`default_nettype none

`include "multi_channel_quiet_debouncer_macros.svh"

module multi_channel_quiet_debouncer #(
    parameter int LINE_COUNT  = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [mcqd_pkg::FIELD_W-1:0]  i_raw_levels,
    // output channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [mcqd_pkg::FIELD_W-1:0]       o_stable_levels,
    output logic [mcqd_pkg::FIELD_W-1:0]       o_changed_mask,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [mcqd_pkg::INDEX_W-1:0]  i_cfg_index,
    input  wire logic [mcqd_pkg::CFG_W-1:0]    i_cfg_data
);

    // Configuration registers.
    logic [mcqd_pkg::CFG_W-1:0]   r_button_quiet;
    logic [mcqd_pkg::CFG_W-1:0]   r_sensor_quiet;
    logic [mcqd_pkg::FIELD_W-1:0] r_sensor_sel;
    logic [mcqd_pkg::FIELD_W-1:0] r_active_low;

    logic r_primed;

    logic                   accept;
    logic                   w_full;
    mcqd_pkg::t_lane_ctl    w_ctl;
    mcqd_pkg::t_lane_res    w_lane [LINE_COUNT];
    logic [COUNT_WIDTH-1:0] w_button_len;
    logic [COUNT_WIDTH-1:0] w_sensor_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_quiet <= mcqd_pkg::BUTTON_QUIET_RST;
            r_sensor_quiet <= mcqd_pkg::SENSOR_QUIET_RST;
            r_sensor_sel   <= mcqd_pkg::SENSOR_SEL_RST;
            r_active_low   <= mcqd_pkg::ACTIVE_LOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mcqd_pkg::REG_BUTTON_QUIET: r_button_quiet <= i_cfg_data;
                mcqd_pkg::REG_SENSOR_QUIET: r_sensor_quiet <= i_cfg_data;
                mcqd_pkg::REG_SENSOR_SEL:
                    r_sensor_sel <= i_cfg_data[mcqd_pkg::FIELD_W-1:0];
                mcqd_pkg::REG_ACTIVE_LOW:
                    r_active_low <= i_cfg_data[mcqd_pkg::FIELD_W-1:0];
            endcase
        end
    end

    // Take a transaction whenever the skid stage is free.
    assign o_stall = w_full;
    assign accept  = i_valid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else if (accept) begin
            r_primed <= 1'b1;
        end
    end

    assign w_ctl.accept = accept;
    assign w_ctl.primed = r_primed;

    // Quiet lengths, saturated to the counter range when the counter is narrow.
    generate
        if (COUNT_WIDTH >= mcqd_pkg::CFG_W) begin : g_len_wide
            assign w_button_len = COUNT_WIDTH'(r_button_quiet);
            assign w_sensor_len = COUNT_WIDTH'(r_sensor_quiet);
        end else begin : g_len_sat
            assign w_button_len = (|r_button_quiet[mcqd_pkg::CFG_W-1:COUNT_WIDTH])
                                  ? '1 : r_button_quiet[COUNT_WIDTH-1:0];
            assign w_sensor_len = (|r_sensor_quiet[mcqd_pkg::CFG_W-1:COUNT_WIDTH])
                                  ? '1 : r_sensor_quiet[COUNT_WIDTH-1:0];
        end
    endgenerate

    // One lane per line; lines beyond the field width see a zero level and polarity and the button quiet length.
    generate
        for (genvar i = 0; i < LINE_COUNT; i++) begin : g_lane
            logic                   w_raw;
            logic                   w_al;
            logic [COUNT_WIDTH-1:0] w_len;
            if (i < mcqd_pkg::FIELD_W) begin : g_wired
                assign w_raw = i_raw_levels[i];
                assign w_al  = r_active_low[i];
                assign w_len = r_sensor_sel[i] ? w_sensor_len : w_button_len;
            end else begin : g_unwired
                assign w_raw = 1'b0;
                assign w_al  = 1'b0;
                assign w_len = w_button_len;
            end
            mcqd_lane #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_raw        (w_raw),
                .i_active_low (w_al),
                .i_quiet_len  (w_len),
                .o_res        (w_lane[i])
            );
        end
    endgenerate

    // Merge lane results and hold them for the output side.
    mcqd_outbuf #(
        .LINE_COUNT (LINE_COUNT)
    ) u_outbuf (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (accept),
        .i_lane          (w_lane),
        .o_full          (w_full),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_stable_levels (o_stable_levels),
        .o_changed_mask  (o_changed_mask)
    );

    // A full skid stage always sits behind a valid output register.
    `MCQD_ASSERT_NOW(a_skid_behind_out, w_full, o_valid)
    // The first accepted transaction primes the block.
    `MCQD_ASSERT_NEXT(a_prime_on_accept, accept && !r_primed, r_primed)
    // Draining the output with the skid stage full leaves a result in place.
    `MCQD_ASSERT_NEXT(a_skid_refills_out, o_valid && !i_stall && w_full, o_valid && !w_full)

endmodule

`default_nettype wire
